// ===== design/apj_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package apj_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicW = 28;
  localparam int AngleW = 20;
  localparam logic signed [AngleW-1:0] AnglePi = 20'sd205887;
  localparam logic [17:0] DepthMax = 18'd262143;

  function automatic logic signed [AngleW-1:0] atan_entry(input logic [3:0] i);
    logic signed [AngleW-1:0] v;
    unique case (i)
      4'd0: v = 20'sd51472;
      4'd1: v = 20'sd30386;
      4'd2: v = 20'sd16055;
      4'd3: v = 20'sd8150;
      4'd4: v = 20'sd4091;
      4'd5: v = 20'sd2047;
      4'd6: v = 20'sd1024;
      4'd7: v = 20'sd512;
      4'd8: v = 20'sd256;
      4'd9: v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/arm_pose_to_joint_angles_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pose to joint angle converter, fully pipelined.
// Input channel (in_valid, in_stall) takes one pose word per cycle: five rotation
// entries and the tool position. Output channel (out_valid, out_stall) gives one
// joint word per pose: yaw, pitch, insertion depth, roll and a degenerate flag.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the insertion
// offset; cfg_ready is always high and writes are to be made only while the block
// is idle, which the block itself does not enforce. The joint word passes an
// input register, 24 square root stages for the wrist hypotenuse, 17 CORDIC stages
// and an output register. The position norm runs in parallel in a square root
// pipeline of the same depth. Throughput is one word per cycle.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_stall is raised; an empty output slot lets the pipeline move on.
// Synchronous reset clears all valid bits and sets the offset to 98.
module arm_pose_to_joint_angles_top
  import apj_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] in_rot_r00,
  input  wire signed [15:0] in_rot_r01,
  input  wire signed [15:0] in_rot_r02,
  input  wire signed [15:0] in_rot_r12,
  input  wire signed [15:0] in_rot_r22,
  input  wire signed [17:0] in_pos_x,
  input  wire signed [17:0] in_pos_y,
  input  wire signed [17:0] in_pos_z,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] out_yaw_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic [17:0]       out_insertion_depth,
  output logic signed [15:0] out_roll_angle,
  output logic              out_degenerate,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [15:0]        cfg_data
);
  localparam int TagW = 16 * 5 + 1;
  localparam int CordLat = CordicSteps + 1;

  logic signed [15:0] offset_r;
  logic               en;
  logic               s0_vld_r;
  logic signed [15:0] r00_r, r01_r, r02_r, r12_r, r22_r;
  logic signed [17:0] px_r, py_r, pz_r;
  logic [47:0]        hsq;
  logic [47:0]        nsq;
  logic               h_vld;
  logic [23:0]        h_root;
  logic [25:0]        h_rem;
  logic [TagW-1:0]    h_tag;
  logic               n_vld;
  logic [23:0]        n_root;
  logic [25:0]        n_rem;
  logic [0:0]         n_tag;
  logic [CordLat-1:0] c_vld_r;
  logic [CordLat-1:0] c_deg_r;
  logic [18:0]        nrm_r [CordLat];
  logic signed [15:0] yaw_a, pitch_a, roll_a;
  logic signed [15:0] h12, h22, h00, h01, h02;
  logic               hdeg;
  logic signed [20:0] dsum;
  logic [24:0]        nrm_rnd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 16'sd98;
    end else if (cfg_valid) begin
      offset_r <= cfg_data;
    end
  end

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r00_r <= in_rot_r00;
      r01_r <= in_rot_r01;
      r02_r <= in_rot_r02;
      r12_r <= in_rot_r12;
      r22_r <= in_rot_r22;
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
    end
  end

  assign hsq = {32'(r12_r * r12_r) + 32'(r22_r * r22_r), 16'h0000};
  assign nsq = 48'(36'(px_r * px_r)) + 48'(36'(py_r * py_r)) + 48'(36'(pz_r * pz_r));

  apj_isqrt #(.InW(48), .TagW(TagW)) u_hyp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s0_vld_r),
    .in_val(hsq),
    .in_tag({r00_r, r01_r, r02_r, r12_r, r22_r, (r12_r == '0) && (r22_r == '0)}),
    .out_vld(h_vld), .out_root(h_root), .out_rem(h_rem), .out_tag(h_tag)
  );

  apj_isqrt #(.InW(48), .TagW(1)) u_nrm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s0_vld_r), .in_val(nsq),
    .in_tag(1'b0),
    .out_vld(n_vld), .out_root(n_root), .out_rem(n_rem), .out_tag(n_tag)
  );

  assign {h00, h01, h02, h12, h22, hdeg} = h_tag;

  apj_cordic u_pitch (
    .clk(clk), .en(en),
    .in_y(CordicW'(h02) <<< 8), .in_x(CordicW'({1'b0, h_root})),
    .out_angle(pitch_a)
  );
  apj_cordic u_yaw (
    .clk(clk), .en(en),
    .in_y(CordicW'(h12) <<< 8), .in_x(CordicW'(h22) <<< 8),
    .out_angle(yaw_a)
  );
  apj_cordic u_roll (
    .clk(clk), .en(en),
    .in_y(-(CordicW'(h00) <<< 8)), .in_x(CordicW'(h01) <<< 8),
    .out_angle(roll_a)
  );

  // The norm is rounded and delayed to line up with the angles.
  assign nrm_rnd = (n_rem > 26'(n_root)) ? 25'(n_root) + 25'd1 : 25'(n_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
    end else if (en) begin
      c_vld_r <= {c_vld_r[CordLat-2:0], h_vld};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_deg_r <= {c_deg_r[CordLat-2:0], hdeg};
      nrm_r[0] <= nrm_rnd[18:0];
      for (int i = 1; i < CordLat; i++) begin
        nrm_r[i] <= nrm_r[i-1];
      end
    end
  end

  assign dsum = 21'(nrm_r[CordLat-1]) + 21'(offset_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_vld_r[CordLat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_pitch_angle <= pitch_a;
      out_yaw_angle <= c_deg_r[CordLat-1] ? 16'sd0 : yaw_a;
      out_roll_angle <= c_deg_r[CordLat-1] ? 16'sd0 : roll_a;
      out_degenerate <= c_deg_r[CordLat-1];
      if (dsum < 0) begin
        out_insertion_depth <= '0;
      end else if (dsum > 21'(DepthMax)) begin
        out_insertion_depth <= DepthMax;
      end else begin
        out_insertion_depth <= dsum[17:0];
      end
    end
  end

  logic unused_ok;
  assign unused_ok = ^{n_vld, n_tag, h_rem, nrm_rnd[24:19]};
endmodule
`default_nettype wire

// ===== design/apj_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module apj_isqrt
  import apj_pkg::*;
#(
  parameter int InW = 48,
  parameter int TagW = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_vld,
  input  wire [InW-1:0]        in_val,
  input  wire [TagW-1:0]       in_tag,
  output logic                 out_vld,
  output logic [InW/2-1:0]     out_root,
  output logic [InW/2+1:0]     out_rem,
  output logic [TagW-1:0]      out_tag
);
  localparam int N = InW / 2;
  localparam int RW = N + 2;

  logic [N:1]           vld_r;
  logic [InW-1:0]       val_r [1:N];
  logic [N-1:0]         root_r [1:N];
  logic [RW-1:0]        rem_r [1:N];
  logic [TagW-1:0]      tag_r [1:N];
  logic                 unused_ok;

  for (genvar s = 0; s < N; s++) begin : g_stg
    logic          v_in;
    logic [InW-1:0] val_in;
    logic [N-1:0]  root_in;
    logic [RW-1:0] rem_in;
    logic [TagW-1:0] tag_in;
    logic [RW-1:0] trial;
    logic [RW-1:0] cand;
    logic [RW-1:0] rem_nxt;
    logic [N-1:0] root_nxt;
    if (s == 0) begin : g_head
      assign v_in = in_vld;
      assign val_in = in_val;
      assign root_in = '0;
      assign rem_in = '0;
      assign tag_in = in_tag;
    end else begin : g_body
      assign v_in = vld_r[s];
      assign val_in = val_r[s];
      assign root_in = root_r[s];
      assign rem_in = rem_r[s];
      assign tag_in = tag_r[s];
    end
    always_comb begin
      cand = {rem_in[RW-3:0], val_in[InW-1 -: 2]};
      trial = {root_in, 2'b01};
      if (cand >= trial) begin
        rem_nxt = cand - trial;
        root_nxt = {root_in[N-2:0], 1'b1};
      end else begin
        rem_nxt = cand;
        root_nxt = {root_in[N-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        val_r[s+1] <= {val_in[InW-3:0], 2'b00};
        root_r[s+1] <= root_nxt;
        rem_r[s+1] <= rem_nxt;
        tag_r[s+1] <= tag_in;
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_root = root_r[N];
  assign out_rem = rem_r[N];
  assign out_tag = tag_r[N];
  assign unused_ok = ^val_r[N];
endmodule
`default_nettype wire

// ===== design/apj_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined vectoring CORDIC, one rotation per stage, angle rounded to 2^-13 rad.
module apj_cordic
  import apj_pkg::*;
(
  input  wire                       clk,
  input  wire                       en,
  input  wire signed [CordicW-1:0]  in_y,
  input  wire signed [CordicW-1:0]  in_x,
  output logic signed [15:0]        out_angle
);
  logic signed [CordicW-1:0] x_r [CordicSteps+1];
  logic signed [CordicW-1:0] y_r [CordicSteps+1];
  logic signed [AngleW-1:0]  z_r [CordicSteps+1];
  logic                      zero_r [CordicSteps+1];
  logic signed [AngleW-1:0]  zr;
  logic signed [AngleW-1:0]  rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= (in_y >= 0) ? AnglePi : -AnglePi;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(4'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(4'(i));
        end
      end
    end
  end

  always_comb begin
    zr = z_r[CordicSteps] + 20'sd4;
    rnd = zr >>> 3;
    if (zero_r[CordicSteps]) begin
      out_angle = '0;
    end else if (rnd > 20'sd32767) begin
      out_angle = 16'sh7fff;
    end else if (rnd < -20'sd32768) begin
      out_angle = 16'sh8000;
    end else begin
      out_angle = rnd[15:0];
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import apj_pkg::*;

  typedef struct packed {
    logic signed [15:0] r00, r01, r02, r12, r22;
    logic signed [17:0] px, py, pz;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic [17:0] depth;
    logic signed [15:0] roll;
    logic degen;
  } joints_t;

  typedef struct {
    pose_t p;
    logic known;
    joints_t j;
  } row_t;

  localparam int PoseW = $bits(pose_t);
  localparam int Latency = 42;
  localparam int WatchLimit = 20000;
  localparam logic signed [63:0] QuarterTurn = 64'sd102944;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic signed [15:0] in_rot_r00, in_rot_r01, in_rot_r02, in_rot_r12, in_rot_r22;
  logic signed [17:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [15:0] out_yaw_angle, out_pitch_angle, out_roll_angle;
  logic [17:0] out_insertion_depth;
  logic out_degenerate;
  logic [15:0] cfg_data;

  arm_pose_to_joint_angles_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rot_r00(in_rot_r00), .in_rot_r01(in_rot_r01), .in_rot_r02(in_rot_r02),
    .in_rot_r12(in_rot_r12), .in_rot_r22(in_rot_r22),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_yaw_angle(out_yaw_angle), .out_pitch_angle(out_pitch_angle),
    .out_insertion_depth(out_insertion_depth), .out_roll_angle(out_roll_angle),
    .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  logic signed [15:0] offset_reg;
  joints_t pending_joints[$];
  int errors = 0;
  int quiet = 0;
  bit hold_out = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] vector_angle(longint y, longint x);
    longint z, xs, ys, r;
    z = 0;
    if (x == 0 && y == 0) return 16'sd0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(AnglePi) : -longint'(AnglePi);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_entry(4'(i)));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_entry(4'(i)));
      end
    end
    r = asr(z + 4, 3);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic joints_t solve_joints(pose_t p);
    joints_t j;
    longint hyp, nsq, nrm, d;
    j.degen = (p.r12 == 0 && p.r22 == 0);
    hyp = root_floor((longint'(p.r12) * p.r12 + longint'(p.r22) * p.r22) <<< 16);
    j.pitch = vector_angle(longint'(p.r02) * 256, hyp);
    j.yaw = 0;
    j.roll = 0;
    if (!j.degen) begin
      j.yaw = vector_angle(longint'(p.r12) * 256, longint'(p.r22) * 256);
      j.roll = vector_angle(-longint'(p.r00) * 256, longint'(p.r01) * 256);
    end
    nsq = longint'(p.px) * p.px + longint'(p.py) * p.py + longint'(p.pz) * p.pz;
    nrm = root_floor(nsq);
    if (nsq - nrm * nrm > nrm) nrm++;
    d = nrm + longint'(offset_reg);
    if (d < 0) d = 0;
    if (d > longint'(DepthMax)) d = longint'(DepthMax);
    j.depth = 18'(d);
    return j;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    int k;
    p = pose_t'(PoseW'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    k = $urandom_range(0, 9);
    if (k == 0) begin
      p.r12 = 0;
      p.r22 = 0;
    end else if (k == 1) begin
      p.r01 = 0;
      p.r00 = ($urandom_range(0, 1)) ? 16'sd0 : p.r00;
    end else if (k == 2) begin
      p.px = $signed(18'($urandom_range(0, 2000))) - 18'sd1000;
      p.py = 0;
      p.pz = 0;
    end
    return p;
  endfunction

  task automatic send_pose(pose_t p);
    in_rot_r00 <= p.r00;
    in_rot_r01 <= p.r01;
    in_rot_r02 <= p.r02;
    in_rot_r12 <= p.r12;
    in_rot_r22 <= p.r22;
    in_pos_x <= p.px;
    in_pos_y <= p.py;
    in_pos_z <= p.pz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
        (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_joints.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic write_offset(logic signed [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    offset_reg = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_joints.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        joints_t e;
        e = pending_joints.pop_front();
        if (out_yaw_angle !== e.yaw) report_mismatch("yaw", out_yaw_angle, e.yaw);
        if (out_pitch_angle !== e.pitch)
          report_mismatch("pitch", out_pitch_angle, e.pitch);
        if (out_insertion_depth !== e.depth)
          report_mismatch("depth", out_insertion_depth, e.depth);
        if (out_roll_angle !== e.roll) report_mismatch("roll", out_roll_angle, e.roll);
        if (out_degenerate !== e.degen)
          report_mismatch("degenerate", out_degenerate, e.degen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_out) begin
      out_stall <= 1'b1;
    end else if (out_stall) begin
      out_stall <= ($urandom_range(0, 2) != 0);
    end else begin
      out_stall <= ($urandom_range(0, 5) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WatchLimit) begin
      $display("arm_pose_to_joint_angles_top regression: fail");
      $finish;
    end
  end

  task automatic long_hold();
    hold_out = 1;
    repeat (120) @(posedge clk);
    hold_out = 0;
  endtask

  row_t rows[$];

  task automatic add_row(pose_t p, logic known, joints_t j);
    row_t r;
    r.p = p;
    r.known = known;
    r.j = j;
    rows.push_back(r);
  endtask

  initial begin
    pose_t p;
    joints_t j;
    rst_n = 0;
    in_valid = 0;
    cfg_valid = 0;
    cfg_data = 0;
    in_rot_r00 = 0; in_rot_r01 = 0; in_rot_r02 = 0; in_rot_r12 = 0; in_rot_r22 = 0;
    in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    offset_reg = 16'sd98;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    p = '0;
    j = '{yaw: 0, pitch: 0, depth: 18'd98, roll: 0, degen: 1};
    add_row(p, 1, j);
    p.r02 = 16'sd32767;
    j.pitch = 16'(asr(QuarterTurn + 4, 3));
    add_row(p, 1, j);
    p.r02 = -16'sd32768;
    j.pitch = 16'(asr(-QuarterTurn + 4, 3));
    add_row(p, 1, j);
    p = '0;
    p.px = 18'sd131071; p.py = 18'sd131071; p.pz = 18'sd131071;
    j = '{yaw: 0, pitch: 0, depth: DepthMax, roll: 0, degen: 1};
    add_row(p, 0, j);
    p = '0;
    p.r22 = -16'sd32768;
    p.r00 = 16'sd100;
    add_row(p, 0, j);
    p = '0;
    p.r22 = 16'sd32767; p.r01 = -16'sd32768;
    add_row(p, 0, j);
    p = '0;
    p.r12 = -16'sd32768; p.r22 = -16'sd32768; p.r00 = -16'sd32768;
    p.r01 = 16'sd32767; p.r02 = 16'sd32767;
    p.px = -18'sd131072; p.py = -18'sd131072; p.pz = -18'sd131072;
    add_row(p, 0, j);
    p = '0;
    p.r12 = 16'sd1; p.r22 = -16'sd1; p.r00 = 16'sd1; p.r01 = -16'sd1;
    p.px = 18'sd3; p.py = -18'sd4;
    add_row(p, 0, j);
    p = '0;
    p.r12 = 16'sd32767; p.r00 = -16'sd32768; p.px = -18'sd1;
    add_row(p, 0, j);

    foreach (rows[i]) begin
      pending_joints.push_back(rows[i].known ? rows[i].j : solve_joints(rows[i].p));
      send_pose(rows[i].p);
    end
    drain();

    write_offset(-16'sd32768);
    for (int i = 0; i < 4; i++) begin
      p = random_pose();
      if (i == 0) begin
        p.px = 18'sd5; p.py = 0; p.pz = 0;
      end
      pending_joints.push_back(solve_joints(p));
      send_pose(p);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_offset(16'sd32767);
        1: write_offset(16'($urandom));
        2: write_offset(-16'sd32768);
        default: write_offset(16'sd98);
      endcase
      fork
        if (phase == 1) long_hold();
        for (int i = 0; i < 110; i++) begin
          p = random_pose();
          pending_joints.push_back(solve_joints(p));
          send_pose(p);
          if (i == 50) begin
            in_valid <= 1'b0;
            while (pending_joints.size() != 0) @(posedge clk);
          end else begin
            random_gap();
          end
        end
      join
      drain();
    end

    if (errors == 0) begin
      $display("arm_pose_to_joint_angles_top regression: pass");
    end else begin
      $display("arm_pose_to_joint_angles_top regression: fail");
    end
    $finish;
  end

endmodule
